FILE: hdl/sut_pkg.sv
package sut_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int NAME_W        = 160;
  localparam int SIZE_W        = 32;
  localparam int POS_W         = 5;
  localparam int COUNT_W       = 6;
  localparam int ENTRY_W       = NAME_W + SIZE_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_INVALID   = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [63:0]       name_chars_lo;
    logic [63:0]       name_chars_mid;
    logic [31:0]       name_chars_hi;
    logic [SIZE_W-1:0] app_size;
    logic [POS_W-1:0]  remove_position;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // zero every character after the first zero character
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              ended;
    ended = 1'b0;
    res   = '0;
    for (int k = 0; k < NAME_W / 8; k++) begin
      res[8*k +: 8] = ended ? 8'h00 : raw[8*k +: 8];
      if (raw[8*k +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

FILE: hdl/sut_ram.sv
module sut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sorted_unique_table.sv
// insert: a scan through the table for a duplicate name (which ends it with a duplicate
//   result) and for the insert position, the first entry of larger size; on a full table a
//   full result, else an upward shift through the table ram, then the result strobe
// remove: a downward shift of the entries above the position through the table ram, then
//   the strobe; a remove at an invalid position strobes on the cycle after the accept
// one table ram port pair sets the rate; reset empties the table at once
module sorted_unique_table #(
  parameter int DEPTH = sut_pkg::DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  sut_pkg::in_t req,
  output logic         busy,
  output logic         done,
  output sut_pkg::out_t result
);

  import sut_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int XW  = (CW > POS_W) ? CW : POS_W;
  localparam int PXW = (AW > POS_W) ? AW : POS_W;
  localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [NAME_W-1:0] name;
  logic [SIZE_W-1:0] size;
  logic [POS_W-1:0]  rpos;
  logic [CW-1:0]     ptr;
  logic              pend;
  logic [AW-1:0]     idx;
  logic              found;
  logic [AW-1:0]     ins;

  logic [CW-1:0]     ptr_dec;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  entry_t            wdata;
  entry_t            rd_data;

  function automatic logic [POS_W-1:0] to_pos(input logic [AW-1:0] p);
    return POS_W'(PXW'(p));
  endfunction

  function automatic logic [COUNT_W-1:0] to_cnt(input logic [CW-1:0] c);
    return COUNT_W'(CXW'(c));
  endfunction

  assign busy    = (state != S_IDLE);
  assign ptr_dec = ptr - CW'(1);

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = idx;
    wdata = rd_data;
    case (state)
      S_SCAN: begin
        raddr = ptr[AW-1:0];
      end
      S_SHIFT_UP: begin
        raddr = ptr_dec[AW-1:0];
        we    = pend;
        if (!pend && ptr <= CW'(ins)) begin
          we    = 1'b1;
          waddr = ins;
          wdata = '{name: name, size: size};
        end
      end
      S_SHIFT_DN: begin
        raddr = ptr[AW-1:0];
        we    = pend;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  sut_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            name  <= clean_name({req.name_chars_hi, req.name_chars_mid, req.name_chars_lo});
            size  <= req.app_size;
            rpos  <= req.remove_position;
            found <= 1'b0;
            ins   <= '0;
            pend  <= 1'b0;
            if (req.command == CMD_INSERT) begin
              ptr   <= '0;
              state <= S_SCAN;
            end else if (XW'(req.remove_position) >= XW'(count)) begin
              done   <= 1'b1;
              result <= '{status: ST_INVALID, position: req.remove_position,
                          entry_count: to_cnt(count)};
            end else begin
              ptr   <= CW'(req.remove_position) + CW'(1);
              state <= S_SHIFT_DN;
            end
          end
        end
        S_SCAN: begin
          if (pend && rd_data.name == name) begin
            pend   <= 1'b0;
            done   <= 1'b1;
            result <= '{status: ST_DUPLICATE, position: to_pos(idx),
                        entry_count: to_cnt(count)};
            state  <= S_IDLE;
          end else begin
            if (pend && !found && rd_data.size > size) begin
              found <= 1'b1;
              ins   <= idx;
            end
            if (ptr < count) begin
              pend <= 1'b1;
              idx  <= ptr[AW-1:0];
              ptr  <= ptr + CW'(1);
            end else begin
              pend <= 1'b0;
              if (!pend) begin
                if (count == CW'(DEPTH)) begin
                  done   <= 1'b1;
                  result <= '{status: ST_FULL, position: '0, entry_count: to_cnt(count)};
                  state  <= S_IDLE;
                end else begin
                  if (!found) begin
                    ins <= count[AW-1:0];
                  end
                  ptr   <= count;
                  state <= S_SHIFT_UP;
                end
              end
            end
          end
        end
        S_SHIFT_UP: begin
          if (ptr > CW'(ins)) begin
            pend <= 1'b1;
            idx  <= ptr[AW-1:0];
            ptr  <= ptr_dec;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count  <= count + CW'(1);
              done   <= 1'b1;
              result <= '{status: ST_INSERTED, position: to_pos(ins),
                          entry_count: to_cnt(count + CW'(1))};
              state  <= S_IDLE;
            end
          end
        end
        S_SHIFT_DN: begin
          if (ptr < count) begin
            pend <= 1'b1;
            idx  <= ptr_dec[AW-1:0];
            ptr  <= ptr + CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count  <= count - CW'(1);
              done   <= 1'b1;
              result <= '{status: ST_REMOVED, position: rpos,
                          entry_count: to_cnt(count - CW'(1))};
              state  <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/sut_chk.sv
module sut_chk (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input sut_pkg::out_t result
);

  import sut_pkg::*;

  // a result closes the operation, so the block is free in that cycle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // every transfer in leads to work or an immediate result
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command left no trace");

  a_full_pos: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> (result.position == '0))
    else $error("full table result with nonzero position");

  a_reset: assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("activity right after reset");

endmodule

bind sorted_unique_table sut_chk u_sut_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

FILE: tb/sorted_unique_table_tb.sv
module sorted_unique_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sut_pkg::*;

  localparam int DEPTH      = DEPTH_DEFAULT;
  localparam int NAME_BYTES = NAME_W / 8;
  localparam int RAND_ITEMS = 650;
  localparam int PHASES     = 8;
  localparam int POOL_SIZE  = 40;
  localparam int DRAIN      = 2 * DEPTH + 8;
  localparam int LIMIT      = 400000;

  typedef logic [NAME_W-1:0] name_t;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } step_t;

  logic  clk   = 1'b0;
  logic  rst   = 1'b1;
  logic  start = 1'b0;
  in_t   req   = '0;
  logic  busy;
  logic  done;
  out_t  result;

  // shadow copy of the table
  name_t       shadow_name[DEPTH];
  logic [31:0] shadow_size[DEPTH];
  int          shadow_count = 0;

  out_t  awaited[$];
  int    errors = 0;
  int    cycles = 0;
  int    peak   = 0;
  int    tally[5];
  name_t pool[POOL_SIZE];
  int    pool_len[POOL_SIZE];
  int    insert_share[PHASES] = '{85, 50, 15, 90, 60, 20, 95, 50};

  sorted_unique_table #(.DEPTH(DEPTH)) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("sorted_unique_table_tb: done, errors");
      $finish;
    end
  end

  // bytes past the first zero byte do not belong to the name
  function automatic name_t terminate(name_t raw);
    name_t nm;
    int    z;
    nm = raw;
    z  = NAME_BYTES;
    for (int k = NAME_BYTES - 1; k >= 0; k--) begin
      if (raw[8*k +: 8] == 8'h00) z = k;
    end
    for (int k = z + 1; k < NAME_BYTES; k++) nm[8*k +: 8] = 8'h00;
    return nm;
  endfunction

  function automatic out_t table_update(in_t r);
    out_t  o;
    name_t nm;
    int    at;
    o = '0;
    if (r.command == CMD_INSERT) begin
      nm = terminate({r.name_chars_hi, r.name_chars_mid, r.name_chars_lo});
      at = -1;
      for (int k = 0; k < shadow_count; k++) begin
        if (at < 0 && shadow_name[k] == nm) at = k;
      end
      if (at >= 0) begin
        o.status   = ST_DUPLICATE;
        o.position = at[POS_W-1:0];
      end else if (shadow_count >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        at = shadow_count;
        for (int k = shadow_count - 1; k >= 0; k--) begin
          if (shadow_size[k] > r.app_size) at = k;
        end
        for (int k = shadow_count; k > at; k--) begin
          shadow_name[k] = shadow_name[k-1];
          shadow_size[k] = shadow_size[k-1];
        end
        shadow_name[at] = nm;
        shadow_size[at] = r.app_size;
        shadow_count++;
        o.status   = ST_INSERTED;
        o.position = at[POS_W-1:0];
      end
    end else begin
      o.position = r.remove_position;
      if (int'(r.remove_position) >= shadow_count) begin
        o.status = ST_INVALID;
      end else begin
        for (int k = int'(r.remove_position); k < shadow_count - 1; k++) begin
          shadow_name[k] = shadow_name[k+1];
          shadow_size[k] = shadow_size[k+1];
        end
        shadow_count--;
        o.status = ST_REMOVED;
      end
    end
    o.entry_count = shadow_count[COUNT_W-1:0];
    return o;
  endfunction

  function automatic name_t text(string s);
    name_t nm;
    nm = '0;
    for (int k = 0; k < s.len() && k < NAME_BYTES; k++) nm[8*k +: 8] = s[k];
    return nm;
  endfunction

  function automatic name_t random_name(int len);
    name_t nm;
    nm = '0;
    for (int k = 0; k < len; k++) nm[8*k +: 8] = 8'($urandom_range(1, 255));
    return nm;
  endfunction

  // junk after the terminating zero byte
  function automatic name_t garble(name_t nm, int len);
    name_t g;
    g = nm;
    for (int k = len + 1; k < NAME_BYTES; k++) g[8*k +: 8] = 8'($urandom);
    return g;
  endfunction

  function automatic step_t row(cmd_t c, name_t nm, logic [31:0] sz, logic [4:0] rp,
                                bit typed = 1'b0, status_t st = ST_INSERTED,
                                int p = 0, int n = 0);
    step_t s;
    s.req.command = c;
    {s.req.name_chars_hi, s.req.name_chars_mid, s.req.name_chars_lo} = nm;
    s.req.app_size        = sz;
    s.req.remove_position = rp;
    s.typed               = typed;
    s.want.status         = st;
    s.want.position       = p[POS_W-1:0];
    s.want.entry_count    = n[COUNT_W-1:0];
    return s;
  endfunction

  function automatic in_t random_command(int share);
    in_t   r;
    name_t nm;
    int    sel;
    int    len;
    int    k;
    r.command         = ($urandom_range(99) < share) ? CMD_INSERT : CMD_REMOVE;
    r.name_chars_lo   = {$urandom, $urandom};
    r.name_chars_mid  = {$urandom, $urandom};
    r.name_chars_hi   = $urandom;
    r.app_size        = $urandom;
    r.remove_position = 5'($urandom_range(31));
    if (r.command == CMD_INSERT) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        k  = $urandom_range(POOL_SIZE - 1);
        nm = garble(pool[k], pool_len[k]);
      end else if (sel < 65 && shadow_count > 0) begin
        nm = shadow_name[$urandom_range(shadow_count - 1)];
      end else begin
        len = $urandom_range(NAME_BYTES);
        nm  = garble(random_name(len), len);
      end
      {r.name_chars_hi, r.name_chars_mid, r.name_chars_lo} = nm;
      sel = $urandom_range(99);
      if (sel < 40) begin
        r.app_size = $urandom_range(15);
      end else if (sel < 50) begin
        r.app_size = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      end
    end else if (shadow_count > 0 && $urandom_range(99) < 80) begin
      r.remove_position = 5'($urandom_range(shadow_count - 1));
    end
    return r;
  endfunction

  // present one command and hold it until the transfer
  task automatic issue(in_t r, bit paced, bit typed, out_t want);
    out_t o;
    if (paced) begin
      while ($urandom_range(99) < 33) begin
        start = 1'b0;
        @(negedge clk);
      end
    end
    start = 1'b1;
    req   = r;
    do @(posedge clk); while (busy);
    o = table_update(r);
    if (typed) o = want;
    awaited.push_back(o);
    tally[int'(o.status)]++;
    if (shadow_count > peak) peak = shadow_count;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    out_t w;
    if (!rst && done) begin
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d position %0d entry_count %0d",
               result.status, result.position, result.entry_count);
        errors++;
      end else begin
        w = awaited.pop_front();
        if (result.status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, result.status);
          errors++;
        end
        if (result.position !== w.position) begin
          $error("position: expected %0d, got %0d", w.position, result.position);
          errors++;
        end
        if (result.entry_count !== w.entry_count) begin
          $error("entry_count: expected %0d, got %0d", w.entry_count, result.entry_count);
          errors++;
        end
      end
    end
  end

  initial begin
    step_t plan[$];
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_len[k] = $urandom_range(1, NAME_BYTES);
      pool[k]     = random_name(pool_len[k]);
    end

    plan.push_back(row(CMD_REMOVE, '0, '0, 5'd0, 1'b1, ST_INVALID, 0, 0));
    plan.push_back(row(CMD_REMOVE, '1, '1, 5'd31, 1'b1, ST_INVALID, 31, 0));
    plan.push_back(row(CMD_INSERT, text("alpha"), 32'h0, 5'd31, 1'b1, ST_INSERTED, 0, 1));
    plan.push_back(row(CMD_INSERT, '1, 32'hFFFF_FFFF, 5'd0, 1'b1, ST_INSERTED, 1, 2));
    plan.push_back(row(CMD_INSERT, garble(text("alpha"), 5), 32'd9, 5'd0,
                       1'b1, ST_DUPLICATE, 0, 2));
    plan.push_back(row(CMD_INSERT, '0, 32'd100, 5'd0, 1'b1, ST_INSERTED, 1, 3));
    plan.push_back(row(CMD_INSERT, garble('0, 0), 32'd5, 5'd0, 1'b1, ST_DUPLICATE, 1, 3));
    plan.push_back(row(CMD_INSERT, text("bravo"), 32'd100, 5'd0));
    plan.push_back(row(CMD_INSERT, text("charlie"), 32'd0, 5'd0));
    plan.push_back(row(CMD_INSERT, {8'hFE, {(NAME_W-8){1'b1}}}, 32'hFFFF_FFFF, 5'd0));
    plan.push_back(row(CMD_INSERT, text("delta"), 32'h7FFF_FFFF, 5'd0));
    plan.push_back(row(CMD_INSERT, text("alpha"), 32'd3, 5'd0));
    plan.push_back(row(CMD_REMOVE, '0, '0, 5'd7));
    plan.push_back(row(CMD_REMOVE, '0, '0, 5'd0));
    plan.push_back(row(CMD_REMOVE, '0, '0, 5'd5));
    plan.push_back(row(CMD_REMOVE, '0, '0, 5'd2));
    plan.push_back(row(CMD_INSERT, text("bravo"), 32'd50, 5'd0));
    plan.push_back(row(CMD_REMOVE, '0, '0, 5'd31));
    plan.push_back(row(CMD_INSERT, text("abcdefghijklmnopqrst"), 32'd1, 5'd0));
    plan.push_back(row(CMD_INSERT, text("abcdefghijklmnopqrsu"), 32'd1, 5'd0));
    plan.push_back(row(CMD_INSERT, text("abcdefghijklmnopqrst"), 32'd9, 5'd0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) issue(plan[i].req, 1'b1, plan[i].typed, plan[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      // let all awaited results come back once before phase 4
      if (ph == 4) begin
        start = 1'b0;
        while (awaited.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      for (int i = 0; i < RAND_ITEMS / PHASES; i++) begin
        issue(random_command(insert_share[ph]), ph != 3, 1'b0, '0);
      end
    end

    start = 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("commands: %0d inserted, %0d duplicate names, %0d refused on a full table",
             tally[ST_INSERTED], tally[ST_DUPLICATE], tally[ST_FULL]);
    $display("commands: %0d removed, %0d bad positions; peak occupancy %0d of %0d",
             tally[ST_REMOVED], tally[ST_INVALID], peak, DEPTH);
    if (errors == 0) begin
      $display("sorted_unique_table_tb: done, clean");
    end else begin
      $display("sorted_unique_table_tb: done, errors");
    end
    $finish;
  end

endmodule
